// File: sv/fstm_pkg.sv
// Package for the frequency set tolerance match block.
// Holds opcode, status and register codes, field widths and the cell control struct.
// No dependencies.
`default_nettype none

package fstm_pkg;

    localparam int FREQ_W   = 32;
    localparam int INDEX_W  = 5;
    localparam int COUNT_W  = 5;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 3'd0,
        OP_APPEND = 3'd1,
        OP_SET    = 3'd2,
        OP_GET    = 3'd3,
        OP_MATCH  = 3'd4
    } fstm_op_t;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    // register indexes of the configuration channel
    localparam logic [1:0] CFG_TOLERANCE     = 2'd0;
    localparam logic [1:0] CFG_USE_INCLUSIVE = 2'd1;

    // per-row command for one cycle
    typedef struct packed {
        logic ins;  // open a slot at pos, shift later entries up
        logic wr;   // overwrite entry at pos
        logic rd;   // capture entry at pos
        logic cmp;  // compare every live entry against the frequency
        logic ld;   // load the hit and read flags; hold them otherwise
    } fstm_ctl_t;

endpackage

`default_nettype wire

// File: sv/fstm_cell.sv
// One table entry of the frequency set: storage, shift-in from its lower
// neighbor, tolerance compare and positional read. Uses fstm_pkg.
`default_nettype none

module fstm_cell
    import fstm_pkg::*;
#(
    parameter int POS = 0,
    parameter int CW  = 5,
    parameter int XW  = 5
) (
    input  wire logic              clk,
    input  wire fstm_ctl_t         ctl,
    input  wire logic [XW-1:0]     pos,
    input  wire logic [CW-1:0]     count,
    input  wire logic [FREQ_W-1:0] freq,
    input  wire logic [FREQ_W-1:0] tolerance,
    input  wire logic [FREQ_W-1:0] prev_entry,
    output logic      [FREQ_W-1:0] entry,
    output logic                   hit,
    output logic      [FREQ_W-1:0] rd_data
);

    localparam logic [XW-1:0] MY_POS = XW'(POS);

    logic [FREQ_W-1:0] entry_reg;
    logic              hit_reg;
    logic [FREQ_W-1:0] rd_reg;
    logic              at_pos;
    logic              above;
    logic              live;
    logic [FREQ_W-1:0] distance;

    assign at_pos   = (pos == MY_POS);
    assign above    = (MY_POS > pos);
    assign live     = (MY_POS < XW'(count));
    assign distance = (entry_reg >= freq) ? (entry_reg - freq) : (freq - entry_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.ins && at_pos)
        begin
            entry_reg <= freq;
        end
        else if (ctl.ins && above)
        begin
            entry_reg <= prev_entry;
        end
        else if (ctl.wr && at_pos)
        begin
            entry_reg <= freq;
        end
        // hold the flags while the result waits on the output
        if (ctl.ld)
        begin
            hit_reg <= ctl.cmp && live && (distance < tolerance);
            rd_reg  <= (ctl.rd && at_pos) ? entry_reg : '0;
        end
    end

    assign entry   = entry_reg;
    assign hit     = hit_reg;
    assign rd_data = rd_reg;

endmodule

`default_nettype wire

// File: sv/fstm_row.sv
// Row of DEPTH fstm_cell instances forming one ordered table; each cell
// takes its lower neighbor's entry on insert. Uses fstm_pkg, fstm_cell.
`default_nettype none

module fstm_row
    import fstm_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int CW    = 5,
    parameter int XW    = 5
) (
    input  wire logic              clk,
    input  wire fstm_ctl_t         ctl,
    input  wire logic [XW-1:0]     pos,
    input  wire logic [CW-1:0]     count,
    input  wire logic [FREQ_W-1:0] freq,
    input  wire logic [FREQ_W-1:0] tolerance,
    output logic                   any_hit,
    output logic      [FREQ_W-1:0] rd_data
);

    logic [FREQ_W-1:0] entries [DEPTH];
    logic [FREQ_W-1:0] reads   [DEPTH];
    logic [DEPTH-1:0]  hits;

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        logic [FREQ_W-1:0] prev;
        if (k == 0)
        begin : g_first
            assign prev = freq;
        end
        else
        begin : g_link
            assign prev = entries[k-1];
        end

        fstm_cell #(
            .POS (k),
            .CW  (CW),
            .XW  (XW)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .pos        (pos),
            .count      (count),
            .freq       (freq),
            .tolerance  (tolerance),
            .prev_entry (prev),
            .entry      (entries[k]),
            .hit        (hits[k]),
            .rd_data    (reads[k])
        );
    end

    assign any_hit = |hits;

    // only the addressed cell holds a nonzero read word
    always_comb
    begin
        rd_data = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            rd_data = rd_data | reads[k];
        end
    end

endmodule

`default_nettype wire

// File: sv/frequency_set_tolerance_match.sv
// Top level of the frequency set tolerance match block.
// Uses fstm_pkg and two fstm_row instances (inclusive and exclusive tables).
`default_nettype none

// Keeps two ordered tables of unsigned Q18.14 frequencies, inclusive and
// exclusive, each a row of DEPTH cells. A transaction on the slave side
// carries one command: insert (later entries shift up one cell), append,
// set, get or match. Match rejects a frequency lying strictly within
// match_tolerance of any live exclusive entry; otherwise it accepts when
// use_inclusive is 0 or some live inclusive entry lies strictly within the
// tolerance. A bad index or a full table answers a status code and leaves
// the tables alone. Every command gives exactly one result transaction.
// Timing: after acceptance the command runs through the execute state, where
// every cell of the selected row shifts, writes or reads in parallel, or for
// a match every cell of both rows compares, and registers its flag; then the
// resolve state OR-reduces the row flags into the output register. A new
// command is accepted on the edge that loads that register, so none is taken
// before the last result has reached it. The output register decouples the
// master side; while it is stalled, the finished result holds and the next
// command waits. The entry storage has no reset; only entries below the
// count are ever read. Configuration writes are taken at any time
// (cfg_ready is tied high) and must come only while the block is idle.
module frequency_set_tolerance_match
    import fstm_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // slave side
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,  // [4:0] entry_index, [36:5] frequency
    input  wire logic [3:0]  s_tuser,  // [2:0] opcode, [3] table_select
    // master side
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata,  // [31:0] read_value, [36:32] entry_count,
                                       // [37] matched, [39:38] status
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index, // 0 match_tolerance, 1 use_inclusive
    input  wire logic [31:0] cfg_data
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > INDEX_W) ? CW : INDEX_W;
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE    = 3'b001,
        S_EXEC    = 3'b010,
        S_RESOLVE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [FREQ_W-1:0] tol_reg;
    logic              use_incl_reg;

    // captured command
    logic [OP_W-1:0]    op_reg;
    logic               sel_reg;
    logic [INDEX_W-1:0] idx_reg;
    logic [FREQ_W-1:0]  freq_reg;

    // table counts
    logic [CW-1:0] icnt_reg, icnt_next;
    logic [CW-1:0] ecnt_reg, ecnt_next;

    // execute-stage results held for the resolve cycle
    logic [STATUS_W-1:0] status_reg;
    logic                is_match_reg;

    // output register
    logic        m_tvalid_reg;
    logic [39:0] m_tdata_reg;

    logic s_accept;
    logic out_free;
    logic exec;

    // execute decode
    logic [CW-1:0]       cnt;
    logic [XW-1:0]       pos;
    logic                is_ins;
    logic                is_set;
    logic                is_get;
    logic                is_match;
    logic                bad_index;
    logic                full;
    logic [STATUS_W-1:0] status;
    logic                ok;
    fstm_ctl_t           ctl_incl;
    fstm_ctl_t           ctl_excl;

    // row outputs
    logic              incl_hit;
    logic              excl_hit;
    logic [FREQ_W-1:0] incl_rd;
    logic [FREQ_W-1:0] excl_rd;

    // resolve
    logic          matched;
    logic [CW-1:0] sel_cnt;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE) || ((state_reg == S_RESOLVE) && out_free);
    assign s_accept  = s_tvalid && s_tready;
    assign exec      = (state_reg == S_EXEC);

    // configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg      <= FREQ_W'(16384);
            use_incl_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TOLERANCE:     tol_reg      <= cfg_data;
                CFG_USE_INCLUSIVE: use_incl_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // capture command payload on acceptance
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            op_reg   <= s_tuser[2:0];
            sel_reg  <= s_tuser[3];
            idx_reg  <= s_tdata[4:0];
            freq_reg <= s_tdata[36:5];
        end
    end

    // decode against the selected table's count
    always_comb
    begin
        cnt       = sel_reg ? ecnt_reg : icnt_reg;
        is_ins    = (op_reg == OP_INSERT) || (op_reg == OP_APPEND);
        is_set    = (op_reg == OP_SET);
        is_get    = (op_reg == OP_GET);
        is_match  = (op_reg == OP_MATCH);
        // append lands at the current end of the table
        pos       = (op_reg == OP_APPEND) ? XW'(cnt) : XW'(idx_reg);
        full      = (cnt == FULL_COUNT);
        bad_index = 1'b0;
        status    = ST_OK;
        if (is_ins)
        begin
            bad_index = (pos > XW'(cnt));
            if (bad_index)
            begin
                status = ST_BAD_INDEX;
            end
            else if (full)
            begin
                status = ST_FULL;
            end
        end
        else if (is_set || is_get)
        begin
            bad_index = (pos >= XW'(cnt));
            if (bad_index)
            begin
                status = ST_BAD_INDEX;
            end
        end
        ok = (status == ST_OK);

        ctl_incl.ins = exec && is_ins && ok && !sel_reg;
        ctl_incl.wr  = exec && is_set && ok && !sel_reg;
        ctl_incl.rd  = exec && is_get && ok && !sel_reg;
        ctl_incl.cmp = exec && is_match;
        ctl_incl.ld  = exec;
        ctl_excl.ins = exec && is_ins && ok && sel_reg;
        ctl_excl.wr  = exec && is_set && ok && sel_reg;
        ctl_excl.rd  = exec && is_get && ok && sel_reg;
        ctl_excl.cmp = exec && is_match;
        ctl_excl.ld  = exec;

        icnt_next = icnt_reg;
        ecnt_next = ecnt_reg;
        if (ctl_incl.ins)
        begin
            icnt_next = icnt_reg + CW'(1);
        end
        if (ctl_excl.ins)
        begin
            ecnt_next = ecnt_reg + CW'(1);
        end
    end

    fstm_row #(
        .DEPTH (DEPTH),
        .CW    (CW),
        .XW    (XW)
    ) u_incl_row (
        .clk       (clk),
        .ctl       (ctl_incl),
        .pos       (pos),
        .count     (icnt_reg),
        .freq      (freq_reg),
        .tolerance (tol_reg),
        .any_hit   (incl_hit),
        .rd_data   (incl_rd)
    );

    fstm_row #(
        .DEPTH (DEPTH),
        .CW    (CW),
        .XW    (XW)
    ) u_excl_row (
        .clk       (clk),
        .ctl       (ctl_excl),
        .pos       (pos),
        .count     (ecnt_reg),
        .freq      (freq_reg),
        .tolerance (tol_reg),
        .any_hit   (excl_hit),
        .rd_data   (excl_rd)
    );

    // hold execute results for the resolve cycle
    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            status_reg   <= status;
            is_match_reg <= is_match;
        end
    end

    // sequencing: accept, execute, resolve
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_RESOLVE;
            end
            S_RESOLVE:
            begin
                if (out_free)
                begin
                    state_next = s_tvalid ? S_EXEC : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            icnt_reg  <= '0;
            ecnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            icnt_reg  <= icnt_next;
            ecnt_reg  <= ecnt_next;
        end
    end

    // exclusion wins; with use_inclusive set, an empty inclusive table accepts nothing
    assign matched = is_match_reg && !excl_hit && (!use_incl_reg || incl_hit);
    assign sel_cnt = sel_reg ? ecnt_reg : icnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if ((state_reg == S_RESOLVE) && out_free)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_RESOLVE) && out_free)
        begin
            m_tdata_reg <= {status_reg, matched, COUNT_W'(sel_cnt),
                            sel_reg ? excl_rd : incl_rd};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// File: sv/fstm_checker.sv
// Port-level checker for frequency_set_tolerance_match, bound to the top.
// Uses fstm_pkg for the status codes.
`default_nettype none

module fstm_checker
    import fstm_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata
);

    logic [1:0] pend_reg;
    logic       s_acc;
    logic       m_acc;

    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;

    // commands accepted whose result has not yet been taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else if (s_acc && !m_acc)
        begin
            pend_reg <= pend_reg + 2'd1;
        end
        else if (m_acc && !s_acc)
        begin
            pend_reg <= pend_reg - 2'd1;
        end
    end

    // no result without a command behind it
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (pend_reg != 2'd0))
        else $error("result shown with no command outstanding");

    // at most one command in work plus one result waiting
    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 2'd2)
        else $error("too many commands outstanding");

    // every command passes through the execute state, so no back-to-back acceptance
    a_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc |=> !s_tready)
        else $error("command accepted on consecutive cycles");

    // a match answer only comes with ok status and no read word
    a_match_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[37]) |-> ((m_tdata[39:38] == ST_OK) && (m_tdata[31:0] == 32'd0)))
        else $error("matched set with error status or read data");

    // status code stays within the defined set
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[39:38] == ST_OK) || (m_tdata[39:38] == ST_BAD_INDEX) ||
                      (m_tdata[39:38] == ST_FULL)))
        else $error("undefined status code");

endmodule

bind frequency_set_tolerance_match fstm_checker u_fstm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
